// File: rtl/csrspmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector multiply block.
`timescale 1ns / 1ps

package csrspmv_pkg;

	// Request kinds carried in the input tuser.
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_NONZERO = 2'd1;
	localparam logic [1:0] REQ_CLOSE   = 2'd2;

	// Field widths.
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 48;
	localparam int ROW_W  = 16;

	// Extended index width, wide enough to compare against store depths below 2**17.
	localparam int IDXX_W = 17;

	// Packed beat widths.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 64;

	// Saturation limits of the row accumulator.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Control of the vector store for one cycle.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} vs_ctrl_t;

endpackage

// File: rtl/csrspmv_vstore.sv
// Dense vector store: one write port and one registered read port.
`timescale 1ns / 1ps

module csrspmv_vstore
	import csrspmv_pkg::*;
#(
	parameter int VEC_DEPTH = 1024,
	parameter int AW        = $clog2(VEC_DEPTH)
) (
	input  logic                    clk,
	input  vs_ctrl_t                ctrl,
	input  logic [AW-1:0]           wr_addr,
	input  logic signed [VAL_W-1:0] wr_data,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [VAL_W-1:0] rd_data
);

	logic signed [VAL_W-1:0] mem [VEC_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data register holds while the pipeline stalls.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix times dense vector block.
`timescale 1ns / 1ps
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: req_type; tdata: index, vector_value, matrix_value
// m_axis    out        tuser: saturated; tdata: row_index, row_sum
//
// One beat is accepted each cycle while s_axis_tready is high; m_axis_tvalid rises
// after a close-row beat passes the store read stage, the multiply stage and the
// output register.
// The combinational add and clamp of the accumulator sets the rate.
// Reset clears the pipeline flags, the accumulator, the clip flag and the row count;
// the vector store keeps no reset and must be loaded before use.
// A close-row beat waits in the multiply stage, and s_axis_tready drops,
// only while the output register holds a result that has not been taken.

module csr_sparse_matrix_vector_multiply
	import csrspmv_pkg::*;
#(
	parameter int VEC_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [9:0] index, [25:10] vector_value, [41:26] matrix_value, [47:42] zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [15:0] row_index, [63:16] row_sum
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// [0] saturated
	output logic [0:0]           m_axis_tuser
);

	localparam int AW = $clog2(VEC_DEPTH);

	// Input fields.
	logic [1:0]              in_type;
	logic [IDX_W-1:0]        in_index;
	logic signed [VAL_W-1:0] in_vec;
	logic signed [VAL_W-1:0] in_mat;
	logic [IDXX_W-1:0]       idx_ext;
	logic [AW-1:0]           addr;
	logic                    in_range;
	logic                    accept;
	logic                    adv;

	assign in_type  = s_axis_tuser;
	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_vec   = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
	assign in_mat   = s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
	assign idx_ext  = {{(IDXX_W-IDX_W){1'b0}}, in_index};
	assign addr     = idx_ext[AW-1:0];
	assign in_range = idx_ext < IDXX_W'(VEC_DEPTH);

	// Pipeline registers.
	logic                    nz_s1, close_s1, range_s1;
	logic signed [VAL_W-1:0] mat_s1;
	logic signed [VAL_W-1:0] vec_s1;
	logic                    nz_s2, close_s2;
	logic signed [PROD_W-1:0] prod_s2;

	// Accumulator state and output register.
	logic signed [ACC_W-1:0] acc_q;
	logic                    clip_q;
	logic [ROW_W-1:0]        row_q;
	logic                    out_valid_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [ACC_W-1:0]        out_sum_q;
	logic                    out_sat_q;

	// The pipeline halts only when a close meets an untaken result.
	assign adv           = !(close_s2 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// Vector store access.
	vs_ctrl_t vs_ctrl;
	always_comb begin
		vs_ctrl.wr_en = accept && (in_type == REQ_LOAD) && in_range;
		vs_ctrl.rd_en = adv;
	end

	csrspmv_vstore #(
		.VEC_DEPTH (VEC_DEPTH),
		.AW        (AW)
	) u_vstore (
		.clk     (clk),
		.ctrl    (vs_ctrl),
		.wr_addr (addr),
		.wr_data (in_vec),
		.rd_addr (addr),
		.rd_data (vec_s1)
	);

	// Stage one: request decode alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_s1    <= 1'b0;
			close_s1 <= 1'b0;
		end else if (adv) begin
			nz_s1    <= accept && (in_type == REQ_NONZERO);
			close_s1 <= accept && (in_type == REQ_CLOSE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_s1   <= in_mat;
			range_s1 <= in_range;
		end
	end

	// Full-width signed product of the matrix value and the vector element.
	logic signed [PROD_W-1:0] prod_raw;
	assign prod_raw = mat_s1 * vec_s1;

	// Stage two: multiply; a column beyond the store uses zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_s2    <= 1'b0;
			close_s2 <= 1'b0;
		end else if (adv) begin
			nz_s2    <= nz_s1;
			close_s2 <= close_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= range_s1 ? prod_raw : '0;
		end
	end

	// Saturating add of the product to the row accumulator.
	logic signed [ACC_W:0]   sum_wide;
	logic signed [ACC_W-1:0] sum_clamped;
	logic                    sum_clip;

	always_comb begin
		sum_wide = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod_s2);
		if (sum_wide[ACC_W] == sum_wide[ACC_W-1]) begin
			sum_clamped = sum_wide[ACC_W-1:0];
			sum_clip    = 1'b0;
		end else if (sum_wide[ACC_W]) begin
			sum_clamped = ACC_MIN;
			sum_clip    = 1'b1;
		end else begin
			sum_clamped = ACC_MAX;
			sum_clip    = 1'b1;
		end
	end

	// Stage three: accumulate, or close the row and start the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
			row_q  <= '0;
		end else if (adv) begin
			if (close_s2) begin
				acc_q  <= '0;
				clip_q <= 1'b0;
				row_q  <= row_q + ROW_W'(1);
			end else if (nz_s2) begin
				acc_q  <= sum_clamped;
				clip_q <= clip_q | sum_clip;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && close_s2) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && close_s2) begin
			out_row_q <= row_q;
			out_sum_q <= acc_q;
			out_sat_q <= clip_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_sum_q, out_row_q};
	assign m_axis_tuser  = out_sat_q;

endmodule
